>>> rtl/core/gmcr_pkg.sv
// Shared types, codes and constants of the grid move-cost relaxation block.
package gmcr_pkg;

    localparam int DEF_MAX_COLS = 64;
    localparam int DEF_MAX_ROWS = 64;

    localparam logic [6:0] RESET_GRID_WIDTH   = 7'd64;
    localparam logic [6:0] RESET_GRID_HEIGHT  = 7'd64;
    localparam logic [7:0] RESET_DISTANCE_CAP = 8'd72;

    // Request kinds on the input tuser.
    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_RUN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    // Reply kinds on the output tuser.
    localparam logic REPLY_RUN  = 1'b0;
    localparam logic REPLY_READ = 1'b1;

    // Register word indexes on the configuration port.
    localparam logic [1:0] REG_GRID_WIDTH   = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT  = 2'd1;
    localparam logic [1:0] REG_DISTANCE_CAP = 2'd2;

    // Neighbor column and row selectors per direction (0 minus, 1 same, 2 plus).
    localparam logic [1:0] DIR_DX [8] = '{2'd0, 2'd0, 2'd0, 2'd1, 2'd1, 2'd2, 2'd2, 2'd2};
    localparam logic [1:0] DIR_DY [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd0, 2'd1, 2'd2};

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [63:0] costs;
    } cmd_t;

    typedef struct packed {
        logic [6:0] grid_width;
        logic [6:0] grid_height;
        logic [7:0] distance_cap;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic queue_empty;
    } eng_status_t;

endpackage

>>> rtl/core/gmcr_front.sv
// Front end: accepts request words, drops those that do nothing, queues commands.
module gmcr_front
    import gmcr_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,
    input  logic [1:0]  s_tuser,
    output logic        cmd_valid,
    input  logic        cmd_ready,
    output cmd_t        cmd
);

    cmd_t       fifo_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] count_reg, count_next;
    logic       in_storage;
    logic       keep;
    logic       push;
    logic       pop;
    cmd_t       new_cmd;

    assign in_storage = (int'(s_tdata[5:0]) < MAX_COLS) && (int'(s_tdata[11:6]) < MAX_ROWS);

    always_comb
    begin
        new_cmd.col   = s_tdata[5:0];
        new_cmd.row   = s_tdata[11:6];
        new_cmd.costs = s_tdata[75:12];
        new_cmd.op    = OP_READ;
        keep          = 1'b0;
        unique case (s_tuser)
            REQ_LOAD:
            begin
                new_cmd.op = OP_LOAD;
                keep       = in_storage;
            end
            REQ_RUN:
            begin
                new_cmd.op = OP_RUN;
                keep       = 1'b1;
            end
            REQ_READ:
            begin
                new_cmd.op = OP_READ;
                keep       = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign s_tready  = (count_reg != 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = fifo_reg[rptr_reg];
    assign push      = s_tvalid && s_tready && keep;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wptr_next  = push ? ~wptr_reg : wptr_reg;
        rptr_next  = pop ? ~rptr_reg : rptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wptr_reg] <= new_cmd;
        end
    end

endmodule

>>> rtl/core/gmcr_engine.sv
// Back end: cost and distance memories, work queue and the relaxation sequencer.
module gmcr_engine
    import gmcr_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  cmd_t        cmd,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        reply_kind,
    output logic [7:0]  cell_distance,
    output logic [15:0] cells_checked,
    output eng_status_t status
);

    localparam int CW    = $clog2(MAX_COLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int AW    = CW + RW;
    localparam int CELLS = 1 << AW;
    localparam int WU_W  = $clog2(MAX_COLS + 1);
    localparam int HU_W  = $clog2(MAX_ROWS + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CLEAR = 10'b0000000010,
        ST_SEED  = 10'b0000000100,
        ST_POP   = 10'b0000001000,
        ST_FETCH = 10'b0000010000,
        ST_HERE  = 10'b0000100000,
        ST_NREAD = 10'b0001000000,
        ST_NUPD  = 10'b0010000000,
        ST_DONE  = 10'b0100000000,
        ST_RDOUT = 10'b1000000000
    } state_t;

    logic [63:0] cost_mem  [CELLS];
    logic [7:0]  dist_mem  [CELLS];
    logic [AW-1:0] queue_mem [CELLS];
    logic        mark_mem  [CELLS];

    state_t      state_reg, state_next;
    logic [CW-1:0] x_reg, x_next;
    logic [RW-1:0] y_reg, y_next;
    logic [AW-1:0] start_reg, start_next;
    logic        start_ok_reg, start_ok_next;
    logic        rd_out_reg, rd_out_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [AW:0] count_reg, count_next;
    logic [15:0] checked_reg, checked_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] nidx_reg, nidx_next;
    logic [2:0]  k_reg, k_next;
    logic [63:0] costs_reg, costs_next;
    logic [7:0]  here_reg, here_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [7:0]  out_dist_reg, out_dist_next;
    logic [15:0] out_cnt_reg, out_cnt_next;

    logic [63:0] cost_q;
    logic [7:0]  dist_q;
    logic [AW-1:0] queue_q;
    logic        mark_q;

    logic        cost_we;
    logic [AW-1:0] cost_wa;
    logic [AW-1:0] cost_ra;
    logic        dist_we;
    logic [AW-1:0] dist_wa;
    logic [7:0]  dist_wd;
    logic [AW-1:0] dist_ra;
    logic        queue_we;
    logic [AW-1:0] queue_ra;
    logic        mark_we;
    logic [AW-1:0] mark_wa;
    logic        mark_wd;

    logic [WU_W-1:0] w_used;
    logic [HU_W-1:0] h_used;
    logic [AW-1:0] cmd_idx;
    logic        out_free;
    logic [CW-1:0] cx, xm, xp, nx;
    logic [RW-1:0] cy, ym, yp, ny;
    logic [8:0]  cand;

    always_comb
    begin
        if (cfg.grid_width == 7'd0)
            w_used = WU_W'(1);
        else if (int'(cfg.grid_width) > MAX_COLS)
            w_used = WU_W'(MAX_COLS);
        else
            w_used = WU_W'(cfg.grid_width);
        if (cfg.grid_height == 7'd0)
            h_used = HU_W'(1);
        else if (int'(cfg.grid_height) > MAX_ROWS)
            h_used = HU_W'(MAX_ROWS);
        else
            h_used = HU_W'(cfg.grid_height);
    end

    assign cmd_idx  = {RW'(cmd.row), CW'(cmd.col)};
    assign out_free = !out_valid_reg || m_tready;

    // Neighbor coordinates of the current cell for direction k.
    assign cx = cur_reg[CW-1:0];
    assign cy = cur_reg[AW-1:CW];
    assign xm = (cx == '0) ? CW'(w_used - WU_W'(1)) : cx - CW'(1);
    assign xp = ((WU_W'(cx) + WU_W'(1)) >= w_used) ? '0 : cx + CW'(1);
    assign ym = (cy == '0) ? '0 : cy - RW'(1);
    assign yp = ((HU_W'(cy) + HU_W'(1)) >= h_used) ? cy : cy + RW'(1);

    always_comb
    begin
        case (DIR_DX[k_reg])
            2'd0:    nx = xm;
            2'd1:    nx = cx;
            default: nx = xp;
        endcase
        case (DIR_DY[k_reg])
            2'd0:    ny = ym;
            2'd1:    ny = cy;
            default: ny = yp;
        endcase
    end

    assign cand = {1'b0, here_reg} + {1'b0, costs_reg[8*k_reg +: 8]};

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        start_next     = start_reg;
        start_ok_next  = start_ok_reg;
        rd_out_next    = rd_out_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        checked_next   = checked_reg;
        cur_next       = cur_reg;
        nidx_next      = nidx_reg;
        k_next         = k_reg;
        costs_next     = costs_reg;
        here_next      = here_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_dist_next  = out_dist_reg;
        out_cnt_next   = out_cnt_reg;
        cmd_ready      = 1'b0;
        cost_we        = 1'b0;
        cost_wa        = cmd_idx;
        cost_ra        = queue_q;
        dist_we        = 1'b0;
        dist_wa        = {y_reg, x_reg};
        dist_wd        = cfg.distance_cap;
        dist_ra        = cmd_idx;
        queue_we       = 1'b0;
        queue_ra       = head_reg;
        mark_we        = 1'b0;
        mark_wa        = start_reg;
        mark_wd        = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_ready = 1'b1;
                    unique case (cmd.op)
                        OP_LOAD:
                        begin
                            cost_we = 1'b1;
                        end
                        OP_RUN:
                        begin
                            start_next    = cmd_idx;
                            start_ok_next = (int'(cmd.col) < int'(w_used))
                                         && (int'(cmd.row) < int'(h_used));
                            x_next        = '0;
                            y_next        = '0;
                            head_next     = '0;
                            tail_next     = '0;
                            count_next    = '0;
                            checked_next  = '0;
                            state_next    = ST_CLEAR;
                        end
                        default:
                        begin
                            // The read cell is kept so its distance stays on the read port.
                            start_next  = cmd_idx;
                            rd_out_next = (int'(cmd.col) >= MAX_COLS)
                                       || (int'(cmd.row) >= MAX_ROWS);
                            state_next  = ST_RDOUT;
                        end
                    endcase
                end
            end
            ST_CLEAR:
            begin
                dist_we = 1'b1;
                mark_we = 1'b1;
                mark_wa = {y_reg, x_reg};
                mark_wd = 1'b0;
                if ((WU_W'(x_reg) + WU_W'(1)) == w_used)
                begin
                    x_next = '0;
                    y_next = y_reg + RW'(1);
                    if ((HU_W'(y_reg) + HU_W'(1)) == h_used)
                        state_next = ST_SEED;
                end
                else
                begin
                    x_next = x_reg + CW'(1);
                end
            end
            ST_SEED:
            begin
                if (start_ok_reg)
                begin
                    dist_we    = 1'b1;
                    dist_wa    = start_reg;
                    dist_wd    = '0;
                    queue_we   = 1'b1;
                    mark_we    = 1'b1;
                    tail_next  = tail_reg + AW'(1);
                    count_next = count_reg + (AW+1)'(1);
                    state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_POP:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    head_next  = head_reg + AW'(1);
                    count_next = count_reg - (AW+1)'(1);
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cur_next = queue_q;
                cost_ra  = queue_q;
                dist_ra  = queue_q;
                mark_we  = 1'b1;
                mark_wa  = queue_q;
                mark_wd  = 1'b0;
                if (checked_reg != 16'hFFFF)
                    checked_next = checked_reg + 16'd1;
                state_next = ST_HERE;
            end
            ST_HERE:
            begin
                costs_next = cost_q;
                here_next  = dist_q;
                k_next     = '0;
                state_next = ST_NREAD;
            end
            ST_NREAD:
            begin
                nidx_next  = {ny, nx};
                dist_ra    = {ny, nx};
                state_next = ST_NUPD;
            end
            ST_NUPD:
            begin
                if ({1'b0, dist_q} > cand)
                begin
                    dist_we = 1'b1;
                    dist_wa = nidx_reg;
                    dist_wd = cand[7:0];
                    if (!mark_q)
                    begin
                        mark_we    = 1'b1;
                        mark_wa    = nidx_reg;
                        queue_we   = 1'b1;
                        tail_next  = tail_reg + AW'(1);
                        count_next = count_reg + (AW+1)'(1);
                    end
                end
                k_next = k_reg + 3'd1;
                if (k_reg == 3'd7)
                    state_next = ST_POP;
                else
                    state_next = ST_NREAD;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = REPLY_RUN;
                    out_dist_next  = '0;
                    out_cnt_next   = checked_reg;
                    state_next     = ST_IDLE;
                end
            end
            ST_RDOUT:
            begin
                dist_ra = start_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = REPLY_READ;
                    out_dist_next  = rd_out_reg ? cfg.distance_cap : dist_q;
                    out_cnt_next   = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            checked_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            checked_reg   <= checked_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        start_reg    <= start_next;
        start_ok_reg <= start_ok_next;
        rd_out_reg   <= rd_out_next;
        cur_reg      <= cur_next;
        nidx_reg     <= nidx_next;
        k_reg        <= k_next;
        costs_reg    <= costs_next;
        here_reg     <= here_next;
        out_kind_reg <= out_kind_next;
        out_dist_reg <= out_dist_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (cost_we)
            cost_mem[cost_wa] <= cmd.costs;
        cost_q <= cost_mem[cost_ra];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
            dist_mem[dist_wa] <= dist_wd;
        dist_q <= dist_mem[dist_ra];
    end

    always_ff @(posedge clk)
    begin
        if (queue_we)
            queue_mem[tail_reg] <= (state_reg == ST_SEED) ? start_reg : nidx_reg;
        queue_q <= queue_mem[queue_ra];
    end

    // Marks of the used grid are cleared by the pass at the start of every run, and no
    // cell outside the used grid is ever marked or looked at.
    always_ff @(posedge clk)
    begin
        if (mark_we)
            mark_mem[mark_wa] <= mark_wd;
        mark_q <= mark_mem[dist_ra];
    end

    assign m_tvalid           = out_valid_reg;
    assign reply_kind         = out_kind_reg;
    assign cell_distance      = out_dist_reg;
    assign cells_checked      = out_cnt_reg;
    assign status.busy        = (state_reg != ST_IDLE);
    assign status.queue_empty = (count_reg == '0);

endmodule

>>> rtl/core/grid_move_cost_relaxation_top.sv
// Top level of the grid move-cost relaxation block: ports, registers, front and engine.
//
// The block keeps eight step costs per grid cell and computes shortest distances from a
// start cell with a FIFO work queue. A load word gives no reply; a read word returns one
// reply word. A run word first writes the cap into every cell of the used grid and clears
// that cell's queued mark, one cell a cycle, then takes cells from the work queue; each
// cell is popped, its queue entry fetched and its costs and distance read, then each of
// its eight neighbors is read and updated in turn, every neighbor compare going through
// the single read port of the distance memory. A short command queue in front lets new
// words be accepted while a run is in progress, and the reply register lets the next
// command start while a reply waits to be taken.
module grid_move_cost_relaxation_top
    import gmcr_pkg::*;
#(
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cell_col[5:0], cell_row[11:6], step_cost_nw, w, sw, n, s, ne, e, se [75:12], zero pad
    input  logic [79:0] s_tdata,
    // req_type[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_distance[7:0], cells_checked[23:8]
    output logic [23:0] m_tdata,
    // reply_kind[0]
    output logic        m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t        cfg_reg;
    logic        cfg_write;
    logic        cmd_valid;
    logic        cmd_ready;
    cmd_t        cmd;
    logic [7:0]  cell_distance;
    logic [15:0] cells_checked;
    eng_status_t status;

    // Configuration registers: written on the access cycle of an APB write.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.grid_width   <= RESET_GRID_WIDTH;
            cfg_reg.grid_height  <= RESET_GRID_HEIGHT;
            cfg_reg.distance_cap <= RESET_DISTANCE_CAP;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_GRID_WIDTH:   cfg_reg.grid_width   <= pwdata[6:0];
                REG_GRID_HEIGHT:  cfg_reg.grid_height  <= pwdata[6:0];
                REG_DISTANCE_CAP: cfg_reg.distance_cap <= pwdata[7:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_GRID_WIDTH:   prdata = {25'd0, cfg_reg.grid_width};
            REG_GRID_HEIGHT:  prdata = {25'd0, cfg_reg.grid_height};
            REG_DISTANCE_CAP: prdata = {24'd0, cfg_reg.distance_cap};
            default:          prdata = '0;
        endcase
    end

    // The front classifies request words; loads outside storage and unknown kinds vanish here.
    gmcr_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    // The engine owns all memories and carries out one command at a time.
    gmcr_engine #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .cmd           (cmd),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .reply_kind    (m_tuser),
        .cell_distance (cell_distance),
        .cells_checked (cells_checked),
        .status        (status)
    );

    assign m_tdata = {cells_checked, cell_distance};

`ifndef SYNTHESIS
    // An idle engine has always drained its work queue.
    a_idle_queue_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !status.busy |-> status.queue_empty)
        else $error("engine idle with a non-empty work queue");

    // A new reply only appears when the engine was working on a command.
    a_reply_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(status.busy))
        else $error("reply produced without a command in progress");

    // Commands are only taken while the engine is idle.
    a_cmd_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd_ready) |-> !status.busy)
        else $error("command taken while engine busy");
`endif

endmodule

>>> test/grid_move_cost_relaxation_top_tb.sv
// Self-checking testbench of the grid move-cost relaxation block: directed table, then random phases.
module grid_move_cost_relaxation_top_tb
    import gmcr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLS = 64;
    localparam int ROWS = 64;
    localparam int CELL_COUNT = COLS * ROWS;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    // One reply the block owes us, in the order it must come out.
    typedef struct {
        logic        kind;
        logic [7:0]  dist_val;
        logic [15:0] checked;
    } reply_t;

    // One row of the directed table. Rows with has_typed carry a hand-written reply.
    typedef struct {
        logic [1:0]  req;
        logic [5:0]  col;
        logic [5:0]  row;
        logic [63:0] costs;
        bit          has_typed;
        logic [7:0]  typed_dist;
        logic [15:0] typed_checked;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    grid_move_cost_relaxation_top dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Our own copy of the block's state and registers.
    logic [63:0] cost_copy [CELL_COUNT];
    logic [7:0]  dist_copy [CELL_COUNT];
    bit          cost_loaded [CELL_COUNT];
    bit          dist_written [CELL_COUNT];
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    logic [7:0]  cap_reg;

    reply_t pending_replies[$];
    int     fail_count;
    int     burst_left;
    dir_row_t dir_rows[$];

    always #5 clk = ~clk;

    // A register value of 0 acts as 1, anything above the storage size acts as that size.
    function automatic int used_width();
        if (width_reg == 0) return 1;
        if (width_reg > COLS) return COLS;
        return int'(width_reg);
    endfunction

    function automatic int used_height();
        if (height_reg == 0) return 1;
        if (height_reg > ROWS) return ROWS;
        return int'(height_reg);
    endfunction

    // Label-correcting relaxation from one start cell; returns the saturated checked count.
    function automatic logic [15:0] relax_from(int col, int row);
        int w;
        int h;
        int cells[$];
        bit in_queue [CELL_COUNT];
        int checked;
        int idx;
        int cx;
        int cy;
        int xs[3];
        int ys[3];
        int nidx;
        int cand;
        w = used_width();
        h = used_height();
        checked = 0;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                dist_copy[y * COLS + x] = cap_reg;
                dist_written[y * COLS + x] = 1'b1;
            end
        if (col >= w || row >= h)
            return 16'd0;
        dist_copy[row * COLS + col] = 8'd0;
        cells.push_back(row * COLS + col);
        in_queue[row * COLS + col] = 1'b1;
        while (cells.size() > 0)
        begin
            idx = cells.pop_front();
            in_queue[idx] = 1'b0;
            if (checked < 65535)
                checked++;
            cx = idx % COLS;
            cy = idx / COLS;
            // Columns wrap; rows clamp to the cell itself at the top and bottom edges.
            xs[0] = (cx == 0) ? w - 1 : cx - 1;
            xs[1] = cx;
            xs[2] = (cx + 1 >= w) ? 0 : cx + 1;
            ys[0] = (cy == 0) ? 0 : cy - 1;
            ys[1] = cy;
            ys[2] = (cy + 1 >= h) ? cy : cy + 1;
            for (int k = 0; k < 8; k++)
            begin
                cand = dist_copy[idx] + cost_copy[idx][8 * k +: 8];
                nidx = ys[DIR_DY[k]] * COLS + xs[DIR_DX[k]];
                if (dist_copy[nidx] > cand)
                begin
                    dist_copy[nidx] = cand[7:0];
                    if (!in_queue[nidx])
                    begin
                        in_queue[nidx] = 1'b1;
                        cells.push_back(nidx);
                    end
                end
            end
        end
        return checked[15:0];
    endfunction

    // Applies one accepted word to the copy and queues the reply it owes, if any.
    task automatic predict_word(input logic [1:0] req, input logic [5:0] col,
                                input logic [5:0] row, input logic [63:0] costs,
                                input bit has_typed, input logic [7:0] typed_dist,
                                input logic [15:0] typed_checked);
        reply_t r;
        int idx;
        idx = row * COLS + col;
        if (req == REQ_LOAD)
        begin
            cost_copy[idx] = costs;
            cost_loaded[idx] = 1'b1;
            return;
        end
        if (req == REQ_RUN)
        begin
            r.kind = REPLY_RUN;
            r.dist_val = 8'd0;
            r.checked = relax_from(col, row);
        end
        else if (req == REQ_READ)
        begin
            r.kind = REPLY_READ;
            r.dist_val = dist_copy[idx];
            r.checked = 16'd0;
        end
        else
            return;
        if (has_typed)
        begin
            r.dist_val = typed_dist;
            r.checked = typed_checked;
        end
        pending_replies.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Sends one word in bursts of random length with random gaps; called at a falling edge.
    task automatic send_word(input logic [1:0] req, input logic [5:0] col,
                             input logic [5:0] row, input logic [63:0] costs,
                             input bit has_typed = 1'b0, input logic [7:0] typed_dist = 8'd0,
                             input logic [15:0] typed_checked = 16'd0);
        if (burst_left == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clk);
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tuser = req;
        s_tdata = {4'b0, costs, row, col};
        do @(posedge clk); while (!s_tready);
        predict_word(req, col, row, costs, has_typed, typed_dist, typed_checked);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    // Waits until every owed reply is in, then lets any trailing loads drain.
    task automatic wait_idle();
        while (pending_replies.size() > 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // Register write with a setup phase and an access phase; called at a falling edge while the block is idle.
    task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {index, 2'b00};
        pwdata = {24'd0, value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (index)
            REG_GRID_WIDTH:   width_reg = value[6:0];
            REG_GRID_HEIGHT:  height_reg = value[6:0];
            REG_DISTANCE_CAP: cap_reg = value;
            default: ;
        endcase
    endtask

    task automatic set_grid(input logic [6:0] w, input logic [6:0] h, input logic [7:0] cap);
        wait_idle();
        write_reg(REG_GRID_WIDTH, {1'b0, w});
        write_reg(REG_GRID_HEIGHT, {1'b0, h});
        write_reg(REG_DISTANCE_CAP, cap);
        // Every cell a run can reach must hold costs before the run starts.
        for (int y = 0; y < used_height(); y++)
            for (int x = 0; x < used_width(); x++)
                if (!cost_loaded[y * COLS + x])
                    send_word(REQ_LOAD, x[5:0], y[5:0], {$urandom, $urandom});
    endtask

    // Reply checker: every reply taken is compared with the oldest owed one.
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch("reply words owed", 1, 0);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("reply_kind", int'(m_tuser), int'(want.kind));
                if (m_tdata[7:0] !== want.dist_val)
                    report_mismatch("cell_distance", int'(m_tdata[7:0]), int'(want.dist_val));
                if (m_tdata[23:8] !== want.checked)
                    report_mismatch("cells_checked", int'(m_tdata[23:8]), int'(want.checked));
            end
        end
    end

    // Receiver stall pattern: the mode is redrawn at random, from always ready to mostly stalled.
    always @(negedge clk)
    begin
        int unsigned tick;
        int unsigned mode;
        tick++;
        if (tick % 64 == 0)
            mode = $urandom_range(0, 3);
        case (mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 0);
            2: m_tready <= ($urandom_range(0, 4) == 0);
            default: m_tready <= ((tick % 8) < 5);
        endcase
    end

    // Hard limit on the whole run.
    initial
    begin
        #20ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        logic [1:0] req;
        logic [5:0] col;
        logic [5:0] row;
        int pick;
        logic [6:0] phase_w [8] = '{7'd5, 7'd1, 7'd0, 7'd127, 7'd64, 7'd1, 7'd4, 7'd3};
        logic [6:0] phase_h [8] = '{7'd3, 7'd1, 7'd4, 7'd1, 7'd1, 7'd5, 7'd4, 7'd2};
        logic [7:0] phase_cap [8] = '{8'd72, 8'd255, 8'd0, 8'd40, 8'd255, 8'd9, 8'd200, 8'd1};
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = REQ_LOAD;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        fail_count = 0;
        burst_left = 0;
        width_reg = RESET_GRID_WIDTH;
        height_reg = RESET_GRID_HEIGHT;
        cap_reg = RESET_DISTANCE_CAP;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part on a 2 by 2 grid: cost extremes, every request kind, a start
        // outside the used grid, a load kept outside the used grid, an unknown request.
        dir_rows = '{
            '{REQ_LOAD, 6'd0, 6'd0, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_LOAD, 6'd1, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0, 16'd0},
            '{REQ_LOAD, 6'd0, 6'd1, 64'h0102_0304_0506_0708, 1'b0, 8'd0, 16'd0},
            '{REQ_LOAD, 6'd1, 6'd1, 64'h0A14_1E28_323C_4650, 1'b0, 8'd0, 16'd0},
            '{REQ_LOAD, 6'd63, 6'd63, 64'h8000_0000_0000_0001, 1'b0, 8'd0, 16'd0},
            '{REQ_RUN, 6'd0, 6'd0, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_READ, 6'd0, 6'd0, 64'h0, 1'b1, 8'd0, 16'd0},
            '{REQ_READ, 6'd1, 6'd0, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_READ, 6'd0, 6'd1, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_READ, 6'd1, 6'd1, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_RUN, 6'd5, 6'd0, 64'h0, 1'b1, 8'd0, 16'd0},
            '{REQ_READ, 6'd1, 6'd1, 64'h0, 1'b1, 8'd72, 16'd0},
            '{REQ_UNUSED, 6'd63, 6'd63, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 8'd0, 16'd0},
            '{REQ_RUN, 6'd1, 6'd1, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_READ, 6'd0, 6'd1, 64'h0, 1'b0, 8'd0, 16'd0},
            '{REQ_RUN, 6'd0, 6'd63, 64'h0, 1'b1, 8'd0, 16'd0},
            '{REQ_READ, 6'd0, 6'd0, 64'h0, 1'b1, 8'd72, 16'd0}
        };
        set_grid(7'd2, 7'd2, 8'd72);
        foreach (dir_rows[i])
            send_word(dir_rows[i].req, dir_rows[i].col, dir_rows[i].row, dir_rows[i].costs,
                      dir_rows[i].has_typed, dir_rows[i].typed_dist, dir_rows[i].typed_checked);

        // Random phases, each with its own grid shape and cap, extremes among them.
        for (int p = 0; p < 8; p++)
        begin
            set_grid(phase_w[p], phase_h[p], phase_cap[p]);
            for (int n = 0; n < 6; n++)
            begin
                // Halfway through phase 3, hold off until every owed reply is in.
                if (p == 3 && n == 3)
                    while (pending_replies.size() > 0)
                        @(negedge clk);
                pick = $urandom_range(0, 19);
                col = 6'($urandom_range(0, used_width() - 1));
                row = 6'($urandom_range(0, used_height() - 1));
                if (pick < 8)
                begin
                    req = REQ_LOAD;
                    if (pick < 2)
                    begin
                        col = 6'($urandom);
                        row = 6'($urandom);
                    end
                end
                else if (pick < 13)
                begin
                    req = REQ_RUN;
                    if (pick == 12)
                    begin
                        col = 6'($urandom);
                        row = 6'($urandom);
                    end
                end
                else if (pick < 19)
                begin
                    req = REQ_READ;
                    if (pick == 18)
                    begin
                        col = 6'($urandom);
                        row = 6'($urandom);
                    end
                    // Never read a distance that no run has written.
                    if (!dist_written[row * COLS + col])
                    begin
                        col = 6'd0;
                        row = 6'd0;
                    end
                end
                else
                    req = REQ_UNUSED;
                send_word(req, col, row, {$urandom, $urandom});
            end
        end

        wait_idle();
        repeat (100) @(negedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/gmcr_pkg.sv
rtl/core/gmcr_front.sv
rtl/core/gmcr_engine.sv
rtl/core/grid_move_cost_relaxation_top.sv
test/grid_move_cost_relaxation_top_tb.sv
